### rtl/bris_pkg.sv
// ----------------------------------------------------------------------------
// bris_pkg
// Shared constants, codes and interface types for the bounded recent-id set.
// ----------------------------------------------------------------------------
package bris_pkg;

   // list capacity and stored key width
   localparam int MAX_SIZE  = 16;
   localparam int KEY_WIDTH = 64;

   // fixed field widths
   localparam int OP_W      = 2;
   localparam int ID_W      = 64;
   localparam int RND_W     = 32;
   localparam int CNT_OUT_W = 5;

   localparam int REQ_TDATA_W = ID_W + RND_W;                  // 96
   localparam int RSP_FLD_W   = ID_W + CNT_OUT_W;              // 69
   localparam int RSP_TDATA_W = ((RSP_FLD_W + 7) / 8) * 8;     // 72
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FLD_W;

   // derived widths
   localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int CNT_W = $clog2(MAX_SIZE + 1);

   // remainder unit: dividend bits retired per cycle
   localparam int DIV_STEP  = 4;
   localparam int DIV_CYC   = RND_W / DIV_STEP;
   localparam int DIV_CNT_W = $clog2(DIV_CYC + 1);

   typedef enum logic [OP_W-1:0] {
      OP_GET    = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_DIV,
      ST_PICK,
      ST_SCAN,
      ST_SHIFT,
      ST_APPEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 rd_en;
      logic [IDX_W-1:0]     rd_addr;
      logic                 wr_en;
      logic [IDX_W-1:0]     wr_addr;
      logic [KEY_WIDTH-1:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      logic             start;
      logic [RND_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] rem;
   } div_rsp_type;

   typedef struct packed {
      logic                 pick_valid;
      logic [ID_W-1:0]      picked_id;
      logic [CNT_OUT_W-1:0] entry_count;
   } res_type;

endpackage

### rtl/bris_mem.sv
// ----------------------------------------------------------------------------
// bris_mem
// Identifier store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bris_mem (
   input  logic                              clock,
   input  bris_pkg::mem_req_type             mem_req,
   output logic [bris_pkg::KEY_WIDTH-1:0]    rd_data
);

   logic [bris_pkg::KEY_WIDTH-1:0] id_mem_ff [bris_pkg::MAX_SIZE];
   logic [bris_pkg::KEY_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         id_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= id_mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bris_div.sv
// ----------------------------------------------------------------------------
// bris_div
// Multi-cycle remainder unit: restoring division, a few dividend bits a cycle.
// ----------------------------------------------------------------------------
module bris_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bris_pkg::div_req_type div_req,
   output bris_pkg::div_rsp_type div_rsp
);

   logic                           busy_ff;
   logic                           done_ff;
   logic [bris_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [bris_pkg::RND_W-1:0]     dvd_ff;
   logic [bris_pkg::RND_W-1:0]     dvd_in;
   logic [bris_pkg::CNT_W-1:0]     rem_ff;
   logic [bris_pkg::CNT_W-1:0]     rem_in;
   logic [bris_pkg::CNT_W-1:0]     dsr_ff;
   logic [bris_pkg::CNT_W:0]       trial;

   // retire DIV_STEP dividend bits, MSB first
   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      trial  = '0;
      for (int k = 0; k < bris_pkg::DIV_STEP; k++) begin
         trial  = {rem_in, dvd_in[bris_pkg::RND_W-1]};
         dvd_in = {dvd_in[bris_pkg::RND_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            trial = trial - {1'b0, dsr_ff};
         end
         rem_in = trial[bris_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= bris_pkg::DIV_CNT_W'(bris_pkg::DIV_CYC);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - bris_pkg::DIV_CNT_W'(1);
            if (cnt_ff == bris_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

### rtl/bris_ctrl.sv
// ----------------------------------------------------------------------------
// bris_ctrl
// Sequencer: search, pick, shift-compaction and append over the id store.
// ----------------------------------------------------------------------------
module bris_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [bris_pkg::OP_W-1:0]          in_op,
   input  logic [bris_pkg::KEY_WIDTH-1:0]     in_key,
   input  logic [bris_pkg::RND_W-1:0]         in_rnd,
   output logic                               res_valid,
   input  logic                               res_ready,
   output bris_pkg::res_type                  res,
   output bris_pkg::mem_req_type              mem_req,
   input  logic [bris_pkg::KEY_WIDTH-1:0]     mem_rd_data,
   output bris_pkg::div_req_type              div_req,
   input  bris_pkg::div_rsp_type              div_rsp
);

   bris_pkg::state_type state_ff, state_in;

   logic [bris_pkg::OP_W-1:0]      op_ff, op_in;
   logic [bris_pkg::KEY_WIDTH-1:0] key_ff, key_in;
   logic [bris_pkg::RND_W-1:0]     rnd_ff, rnd_in;
   logic [bris_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [bris_pkg::CNT_W-1:0]     iss_ff, iss_in;
   logic                           cmp_vld_ff, cmp_vld_in;
   logic [bris_pkg::IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [bris_pkg::CNT_W-1:0]     sh_rd_ff, sh_rd_in;
   logic                           wb_vld_ff, wb_vld_in;
   logic [bris_pkg::IDX_W-1:0]     wb_addr_ff, wb_addr_in;
   logic                           pick_vld_ff, pick_vld_in;
   logic [bris_pkg::KEY_WIDTH-1:0] picked_ff, picked_in;

   logic                       full;
   logic                       found;
   logic                       scan_end;
   logic                       shift_end;
   logic [bris_pkg::CNT_W-1:0] sh_prev;
   logic [bris_pkg::CNT_W-1:0] found_next;

   assign full       = (count_ff == bris_pkg::CNT_W'(bris_pkg::MAX_SIZE));
   assign found      = cmp_vld_ff && (mem_rd_data == key_ff);
   assign scan_end   = (iss_ff == count_ff) && !found;
   assign shift_end  = (sh_rd_ff >= count_ff) && !wb_vld_ff;
   assign sh_prev    = sh_rd_ff - bris_pkg::CNT_W'(1);
   assign found_next = bris_pkg::CNT_W'(cmp_idx_ff) + bris_pkg::CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bris_pkg::ST_IDLE: begin
            if (in_valid) state_in = bris_pkg::ST_DISPATCH;
         end
         bris_pkg::ST_DISPATCH: begin
            case (op_ff)
               bris_pkg::OP_GET: begin
                  if (count_ff == '0) state_in = bris_pkg::ST_DONE;
                  else if (full)      state_in = bris_pkg::ST_PICK;
                  else                state_in = bris_pkg::ST_DIV;
               end
               bris_pkg::OP_ADD,
               bris_pkg::OP_REMOVE: state_in = bris_pkg::ST_SCAN;
               default:             state_in = bris_pkg::ST_DONE;
            endcase
         end
         bris_pkg::ST_DIV: begin
            if (div_rsp.done) state_in = bris_pkg::ST_PICK;
         end
         bris_pkg::ST_PICK: state_in = bris_pkg::ST_DONE;
         bris_pkg::ST_SCAN: begin
            if (found) begin
               state_in = (op_ff == bris_pkg::OP_REMOVE) ? bris_pkg::ST_SHIFT
                                                         : bris_pkg::ST_DONE;
            end else if (scan_end) begin
               if (op_ff == bris_pkg::OP_ADD) begin
                  state_in = full ? bris_pkg::ST_SHIFT : bris_pkg::ST_APPEND;
               end else begin
                  state_in = bris_pkg::ST_DONE;
               end
            end
         end
         bris_pkg::ST_SHIFT: begin
            if (shift_end) begin
               state_in = (op_ff == bris_pkg::OP_ADD) ? bris_pkg::ST_APPEND
                                                      : bris_pkg::ST_DONE;
            end
         end
         bris_pkg::ST_APPEND: state_in = bris_pkg::ST_DONE;
         bris_pkg::ST_DONE: begin
            if (res_ready) state_in = bris_pkg::ST_IDLE;
         end
         default: state_in = bris_pkg::ST_IDLE;
      endcase
   end

   // memory, divider and handshake outputs
   always_comb begin
      in_ready         = (state_ff == bris_pkg::ST_IDLE);
      res_valid        = (state_ff == bris_pkg::ST_DONE);
      mem_req          = '0;
      div_req.start    = 1'b0;
      div_req.dividend = rnd_ff;
      div_req.divisor  = count_ff;
      case (state_ff)
         bris_pkg::ST_DISPATCH: begin
            if ((op_ff == bris_pkg::OP_GET) && (count_ff != '0)) begin
               if (full) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = '0;
               end else begin
                  div_req.start = 1'b1;
               end
            end
         end
         bris_pkg::ST_DIV: begin
            mem_req.rd_en   = div_rsp.done;
            mem_req.rd_addr = div_rsp.rem[bris_pkg::IDX_W-1:0];
         end
         bris_pkg::ST_SCAN: begin
            mem_req.rd_en   = (iss_ff < count_ff);
            mem_req.rd_addr = iss_ff[bris_pkg::IDX_W-1:0];
         end
         bris_pkg::ST_SHIFT: begin
            mem_req.rd_en   = (sh_rd_ff < count_ff);
            mem_req.rd_addr = sh_rd_ff[bris_pkg::IDX_W-1:0];
            mem_req.wr_en   = wb_vld_ff;
            mem_req.wr_addr = wb_addr_ff;
            mem_req.wr_data = mem_rd_data;
         end
         bris_pkg::ST_APPEND: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = count_ff[bris_pkg::IDX_W-1:0];
            mem_req.wr_data = key_ff;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in       = op_ff;
      key_in      = key_ff;
      rnd_in      = rnd_ff;
      count_in    = count_ff;
      iss_in      = iss_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_idx_in  = cmp_idx_ff;
      sh_rd_in    = sh_rd_ff;
      wb_vld_in   = wb_vld_ff;
      wb_addr_in  = wb_addr_ff;
      pick_vld_in = pick_vld_ff;
      picked_in   = picked_ff;
      case (state_ff)
         bris_pkg::ST_IDLE: begin
            if (in_valid) begin
               op_in  = in_op;
               key_in = in_key;
               rnd_in = in_rnd;
            end
         end
         bris_pkg::ST_DISPATCH: begin
            pick_vld_in = 1'b0;
            picked_in   = '0;
            iss_in      = '0;
            cmp_vld_in  = 1'b0;
         end
         bris_pkg::ST_PICK: begin
            pick_vld_in = 1'b1;
            picked_in   = mem_rd_data;
         end
         bris_pkg::ST_SCAN: begin
            // keep one read in flight ahead of the compare
            if (iss_ff < count_ff) begin
               iss_in     = iss_ff + bris_pkg::CNT_W'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = iss_ff[bris_pkg::IDX_W-1:0];
            end else begin
               cmp_vld_in = 1'b0;
            end
            wb_vld_in = 1'b0;
            if (found) begin
               sh_rd_in = found_next;
            end else begin
               // full add drops the oldest entry
               sh_rd_in = bris_pkg::CNT_W'(1);
            end
         end
         bris_pkg::ST_SHIFT: begin
            // read entry i+1, write it to i on the next cycle
            if (sh_rd_ff < count_ff) begin
               sh_rd_in   = sh_rd_ff + bris_pkg::CNT_W'(1);
               wb_vld_in  = 1'b1;
               wb_addr_in = sh_prev[bris_pkg::IDX_W-1:0];
            end else begin
               wb_vld_in = 1'b0;
            end
            if (shift_end) begin
               count_in = count_ff - bris_pkg::CNT_W'(1);
            end
         end
         bris_pkg::ST_APPEND: begin
            count_in = count_ff + bris_pkg::CNT_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bris_pkg::ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         wb_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         wb_vld_ff  <= wb_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      rnd_ff      <= rnd_in;
      iss_ff      <= iss_in;
      cmp_idx_ff  <= cmp_idx_in;
      sh_rd_ff    <= sh_rd_in;
      wb_addr_ff  <= wb_addr_in;
      pick_vld_ff <= pick_vld_in;
      picked_ff   <= picked_in;
   end

   assign res.pick_valid  = pick_vld_ff;
   assign res.picked_id   = bris_pkg::ID_W'(picked_ff);
   assign res.entry_count = bris_pkg::CNT_OUT_W'(count_ff);

endmodule

### rtl/bounded_recent_id_set_top.sv
// ----------------------------------------------------------------------------
// bounded_recent_id_set_top
// Ordered, duplicate-free list of recent identifiers with add, remove and
// random pick, held in a single-port-write synchronous memory.
// ----------------------------------------------------------------------------
//
//   channel  | ports                      | contents
//   ---------+----------------------------+--------------------------------
//   request  | req_tvalid/tready/tdata/   | op in tuser; node_id,
//            | tuser                      | random_value in tdata
//   response | rsp_tvalid/tready/tdata/   | pick_valid in tuser; picked_id,
//            | tuser                      | entry_count in tdata
//
// One operation at a time.
//   get: on a list neither empty nor full, the remainder unit retires 32
//   bits at 4 bits a cycle, then raises a registered done.
//   add/remove: a search, then compaction when entries must move, then
//   an append for an add of a new id.
// The memory read port sets the search and compaction cost.
// Reset (synchronous) empties the list at once; stored words stay undefined.
// A waiting response sits in an output register; the next request is taken
// and processed, and only its completion waits for that register to drain.
// ----------------------------------------------------------------------------
module bounded_recent_id_set_top (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [63:0] node_id, [95:64] random_value
   input  logic [bris_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [1:0] op
   input  logic [bris_pkg::OP_W-1:0]           req_tuser,

   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [63:0] picked_id, [68:64] entry_count, [71:69] zero
   output logic [bris_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // [0] pick_valid
   output logic                                rsp_tuser
);

   bris_pkg::mem_req_type          mem_req;
   logic [bris_pkg::KEY_WIDTH-1:0] mem_rd_data;
   bris_pkg::div_req_type          div_req;
   bris_pkg::div_rsp_type          div_rsp;
   bris_pkg::res_type              res;
   logic                           res_valid;
   logic                           res_ready;

   logic                           rsp_vld_ff;
   bris_pkg::res_type              rsp_res_ff;

   logic [bris_pkg::ID_W-1:0]      node_id;
   logic [bris_pkg::RND_W-1:0]     random_value;

   // unpack the request; narrow the identifier to the stored key width
   assign node_id      = req_tdata[bris_pkg::ID_W-1:0];
   assign random_value = req_tdata[bris_pkg::REQ_TDATA_W-1:bris_pkg::ID_W];

   bris_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_op       (req_tuser),
      .in_key      (node_id[bris_pkg::KEY_WIDTH-1:0]),
      .in_rnd      (random_value),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .div_req     (div_req),
      .div_rsp     (div_rsp)
   );

   bris_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   bris_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // output register: load when empty or draining this cycle
   assign res_ready = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_res_ff.pick_valid;
   assign rsp_tdata  = {{bris_pkg::RSP_PAD_W{1'b0}},
                        rsp_res_ff.entry_count,
                        rsp_res_ff.picked_id};

endmodule
